>>> design/drt_pkg.sv
// Shared types and codes for the diagnostic request tracker.
// Used by the tracker top level; depends on nothing.
package drt_pkg;

	localparam int PENDING_DEPTH_DEF = 16;
	localparam int SERVICE_DEPTH     = 256;
	localparam int MAX_FLAGS         = 16;

	typedef enum logic [2:0] {
		OP_REGISTER   = 3'd0,
		OP_UNREGISTER = 3'd1,
		OP_SUBMIT     = 3'd2,
		OP_COMPLETE   = 3'd3,
		OP_REJECT     = 3'd4,
		OP_TICK       = 3'd5,
		OP_CHECK      = 3'd6,
		OP_STATS      = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_ALREADY     = 3'd1,
		ST_NOT_OFFERED = 3'd2,
		ST_FAILED      = 3'd3,
		ST_FULL        = 3'd4
	} status_t;

	typedef struct packed {
		logic [31:0] id;
		logic [7:0]  svc;
		logic [15:0] sub;
		logic [31:0] arrival;
	} pend_entry_t;

	typedef struct packed {
		logic [31:0] requests;
		logic [31:0] successes;
		logic [31:0] negatives;
		logic [31:0] last_time;
	} svc_cnt_t;

endpackage

>>> design/diag_request_tracker_with_timeout_top.sv
// Diagnostic request tracker with response-pending timer: top level sequencer.
// Uses drt_pkg and two drt_ram instances (pending table, service counters).

// The block takes one word at a time. Register, unregister, tick and read stats make no walk
// of the pending memory. Submit walks the pending memory one entry a cycle; complete and
// reject make the same walk and take as long as submit when they credit a service, and less
// when they do not. A check makes one full walk of the pending memory for each request it
// flags, plus one more that finds none unless the flag limit is reached; with the timer at
// zero it makes no walk. The next word is taken while the last result still waits at the
// output register.
module diag_request_tracker_with_timeout_top #(
	parameter int PENDING_DEPTH = drt_pkg::PENDING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [7:0]  service_id,
	input  logic [15:0] sub_function,
	input  logic [31:0] request_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] result_request_id,
	output logic [7:0]  result_service_id,
	output logic [31:0] request_count,
	output logic [31:0] success_count,
	output logic [31:0] negative_count,
	output logic [31:0] last_request_time,
	output logic [4:0]  flagged_count,
	output logic [31:0] total_requests,
	output logic        last
);
	import drt_pkg::*;

	localparam int PW = $clog2(PENDING_DEPTH);
	localparam int CW = PW + 1;
	localparam int SW = $clog2(SERVICE_DEPTH);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DISP     = 7'b0000010,
		S_SCAN     = 7'b0000100,
		S_SCAN_END = 7'b0001000,
		S_SVC_RD   = 7'b0010000,
		S_SVC_WB   = 7'b0100000,
		S_EMIT     = 7'b1000000
	} state_t;

	state_t state_q;

	logic [15:0] p2_q;
	logic [SERVICE_DEPTH-1:0] svc_valid_q;
	logic [PENDING_DEPTH-1:0] pv_q;
	logic [PENDING_DEPTH-1:0] pf_q;
	logic [31:0] next_id_q;
	logic [31:0] total_q;
	logic [31:0] now_q;

	op_t         op_q;
	logic [7:0]  svc_q;
	logic [15:0] sub_q;
	logic [31:0] rid_q;

	logic [CW-1:0] cnt_q;
	logic          rd_vld_s1;
	logic [PW-1:0] rd_idx_s1;
	logic          hit_q;
	logic [PW-1:0] hit_idx_q;
	logic [31:0]   hit_id_q;
	logic [7:0]    hit_svc_q;
	logic          free_hit_q;
	logic [PW-1:0] free_idx_q;
	logic [4:0]    flag_cnt_q;

	status_t     res_status_q;
	logic [31:0] res_rid_q;
	logic [7:0]  res_svc_q;
	svc_cnt_t    res_cnt_q;
	logic [4:0]  res_flag_q;
	logic        res_last_q;

	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [31:0] out_rid_q;
	logic [7:0]  out_svc_q;
	svc_cnt_t    out_cnt_q;
	logic [4:0]  out_flag_q;
	logic [31:0] out_total_q;
	logic        out_last_q;

	pend_entry_t pend_rdata, pend_wdata;
	logic        pend_we, pend_re;
	logic [PW-1:0] pend_waddr;
	svc_cnt_t    svc_rdata, svc_wdata;
	logic        svc_we, svc_re;
	logic [SW-1:0] svc_addr;

	logic out_free, scan_done, eligible, is_match;

	assign out_free  = !out_valid_q || !out_stall;
	assign scan_done = (cnt_q == CW'(PENDING_DEPTH)) && !rd_vld_s1;
	assign is_match  = pv_q[rd_idx_s1] && (pend_rdata.id == hit_id_q);
	assign eligible  = pv_q[rd_idx_s1] && !pf_q[rd_idx_s1]
		&& ((now_q - pend_rdata.arrival) >= {16'd0, p2_q});

	// Pending table memory.
	assign pend_re    = (state_q == S_SCAN) && (cnt_q != CW'(PENDING_DEPTH));
	assign pend_we    = (state_q == S_SCAN_END) && (op_q == OP_SUBMIT) && (hit_q || free_hit_q);
	assign pend_waddr = hit_q ? hit_idx_q : free_idx_q;
	assign pend_wdata = '{id: next_id_q, svc: svc_q, sub: sub_q, arrival: now_q};

	drt_ram #(.W($bits(pend_entry_t)), .DEPTH(PENDING_DEPTH)) u_pend_ram (
		.clk   (clk),
		.we    (pend_we),
		.waddr (pend_waddr),
		.wdata (pend_wdata),
		.re    (pend_re),
		.raddr (cnt_q[PW-1:0]),
		.rdata (pend_rdata)
	);

	// Service counter memory.
	assign svc_re   = (state_q == S_SVC_RD);
	assign svc_addr = ((op_q == OP_COMPLETE) || (op_q == OP_REJECT)) ? hit_svc_q : svc_q;
	assign svc_we   = ((state_q == S_DISP) && (op_q == OP_REGISTER) && !svc_valid_q[svc_q])
		|| ((state_q == S_SVC_WB) && (op_q != OP_STATS));

	always_comb begin
		svc_wdata = svc_rdata;
		if (state_q == S_DISP) begin
			svc_wdata = '0;
		end else begin
			case (op_q)
				OP_SUBMIT: begin
					svc_wdata.requests  = svc_rdata.requests + 32'd1;
					svc_wdata.last_time = now_q;
				end
				OP_COMPLETE: svc_wdata.successes = svc_rdata.successes + 32'd1;
				OP_REJECT:   svc_wdata.negatives = svc_rdata.negatives + 32'd1;
				default: ;
			endcase
		end
	end

	drt_ram #(.W($bits(svc_cnt_t)), .DEPTH(SERVICE_DEPTH)) u_svc_ram (
		.clk   (clk),
		.we    (svc_we),
		.waddr (svc_addr),
		.wdata (svc_wdata),
		.re    (svc_re),
		.raddr (svc_addr),
		.rdata (svc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			p2_q        <= '0;
			svc_valid_q <= '0;
			pv_q        <= '0;
			pf_q        <= '0;
			next_id_q   <= 32'd1;
			total_q     <= '0;
			now_q       <= '0;
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				p2_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_s1 <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= op_t'(operation);
						svc_q   <= service_id;
						sub_q   <= sub_function;
						rid_q   <= request_id;
						state_q <= S_DISP;
					end
				end

				S_DISP: begin
					res_status_q <= ST_OK;
					res_rid_q    <= '0;
					res_svc_q    <= '0;
					res_cnt_q    <= '0;
					res_flag_q   <= '0;
					res_last_q   <= 1'b1;
					cnt_q        <= '0;
					hit_q        <= 1'b0;
					free_hit_q   <= 1'b0;
					flag_cnt_q   <= '0;
					state_q      <= S_EMIT;
					case (op_q)
						OP_REGISTER: begin
							if (svc_valid_q[svc_q]) begin
								res_status_q <= ST_ALREADY;
							end else begin
								svc_valid_q[svc_q] <= 1'b1;
							end
						end
						OP_UNREGISTER: begin
							if (!svc_valid_q[svc_q]) begin
								res_status_q <= ST_NOT_OFFERED;
							end else begin
								svc_valid_q[svc_q] <= 1'b0;
							end
						end
						OP_SUBMIT: begin
							if (!svc_valid_q[svc_q]) begin
								res_status_q <= ST_NOT_OFFERED;
							end else begin
								hit_id_q <= next_id_q;
								state_q  <= S_SCAN;
							end
						end
						OP_COMPLETE, OP_REJECT: begin
							hit_id_q <= rid_q;
							state_q  <= S_SCAN;
						end
						OP_TICK: begin
							now_q <= now_q + 32'd1;
						end
						OP_CHECK: begin
							if (p2_q != 16'd0) begin
								res_last_q <= 1'b0;
								state_q    <= S_SCAN;
							end
						end
						OP_STATS: begin
							res_svc_q <= svc_q;
							if (!svc_valid_q[svc_q]) begin
								res_status_q <= ST_NOT_OFFERED;
							end else begin
								state_q <= S_SVC_RD;
							end
						end
						default: ;
					endcase
				end

				S_SCAN: begin
					if (cnt_q != CW'(PENDING_DEPTH)) begin
						rd_vld_s1 <= 1'b1;
						rd_idx_s1 <= cnt_q[PW-1:0];
						cnt_q     <= cnt_q + CW'(1);
					end
					if (rd_vld_s1) begin
						if (op_q == OP_CHECK) begin
							// Keep the lowest id among the requests that are due.
							if (eligible && (!hit_q || (pend_rdata.id < hit_id_q))) begin
								hit_q     <= 1'b1;
								hit_idx_q <= rd_idx_s1;
								hit_id_q  <= pend_rdata.id;
								hit_svc_q <= pend_rdata.svc;
							end
						end else begin
							if (is_match && !hit_q) begin
								hit_q     <= 1'b1;
								hit_idx_q <= rd_idx_s1;
								hit_svc_q <= pend_rdata.svc;
							end
							if (!pv_q[rd_idx_s1] && !free_hit_q) begin
								free_hit_q <= 1'b1;
								free_idx_q <= rd_idx_s1;
							end
						end
					end
					if (scan_done) begin
						state_q <= S_SCAN_END;
					end
				end

				S_SCAN_END: begin
					state_q <= S_EMIT;
					case (op_q)
						OP_SUBMIT: begin
							if (hit_q || free_hit_q) begin
								pv_q[pend_waddr] <= 1'b1;
								pf_q[pend_waddr] <= 1'b0;
								state_q          <= S_SVC_RD;
							end else begin
								res_status_q <= ST_FULL;
							end
						end
						OP_COMPLETE, OP_REJECT: begin
							if (!hit_q) begin
								res_status_q <= ST_FAILED;
							end else begin
								pv_q[hit_idx_q] <= 1'b0;
								// A service that went away is not credited.
								if (svc_valid_q[hit_svc_q]) begin
									state_q <= S_SVC_RD;
								end
							end
						end
						default: begin
							if (hit_q) begin
								pf_q[hit_idx_q] <= 1'b1;
								res_rid_q       <= hit_id_q;
								res_svc_q       <= hit_svc_q;
								flag_cnt_q      <= flag_cnt_q + 5'd1;
							end else begin
								res_rid_q  <= '0;
								res_svc_q  <= '0;
								res_flag_q <= flag_cnt_q;
								res_last_q <= 1'b1;
							end
						end
					endcase
				end

				S_SVC_RD: begin
					state_q <= S_SVC_WB;
				end

				S_SVC_WB: begin
					if (op_q == OP_SUBMIT) begin
						res_rid_q <= next_id_q;
						next_id_q <= next_id_q + 32'd1;
						total_q   <= total_q + 32'd1;
					end
					if (op_q == OP_STATS) begin
						res_cnt_q <= svc_rdata;
					end
					state_q <= S_EMIT;
				end

				S_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_rid_q    <= res_rid_q;
						out_svc_q    <= res_svc_q;
						out_cnt_q    <= res_cnt_q;
						out_flag_q   <= res_flag_q;
						out_total_q  <= total_q;
						out_last_q   <= res_last_q;
						if (res_last_q) begin
							state_q <= S_IDLE;
						end else if (flag_cnt_q == 5'(MAX_FLAGS)) begin
							// Flag limit reached: the count word follows.
							res_rid_q  <= '0;
							res_svc_q  <= '0;
							res_flag_q <= flag_cnt_q;
							res_last_q <= 1'b1;
						end else begin
							cnt_q   <= '0;
							hit_q   <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall          = (state_q != S_IDLE);
	assign out_valid         = out_valid_q;
	assign status            = out_status_q;
	assign result_request_id = out_rid_q;
	assign result_service_id = out_svc_q;
	assign request_count     = out_cnt_q.requests;
	assign success_count     = out_cnt_q.successes;
	assign negative_count    = out_cnt_q.negatives;
	assign last_request_time = out_cnt_q.last_time;
	assign flagged_count     = out_flag_q;
	assign total_requests    = out_total_q;
	assign last              = out_last_q;
endmodule

>>> design/drt_ram.sv
// Simple dual-port synchronous RAM with registered read data.
// Holds its read data until the next read; no dependencies.
module drt_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
